### hdl/rbbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rbbe_pkg;

  // Byte codes the scanner reacts to
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  // Most bytes a single input item can produce
  localparam int unsigned MAX_OUT = 3;

  // Scanner mode; code 7 is unused and decodes as outside bracket
  typedef enum logic [2:0] {
    MODE_OUT        = 3'd0,
    MODE_OPEN       = 3'd1,
    MODE_FIRST      = 3'd2,
    MODE_IN         = 3'd3,
    MODE_PEND_OPEN  = 3'd4,
    MODE_CLASS      = 3'd5,
    MODE_PEND_DELIM = 3'd6
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] delim;
    logic       skip;
  } scan_state_t;

  // Bytes produced by one item, chars[0] goes out first
  typedef struct packed {
    logic [1:0]              n;
    logic [MAX_OUT-1:0][7:0] chars;
  } emit_t;

endpackage

`default_nettype wire

### hdl/rbbe_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Next-state and output bytes for one input byte; pure combinational.
module rbbe_step (
  input  rbbe_pkg::scan_state_t st,
  input  logic [7:0]            in_char,
  input  logic                  in_last,
  output rbbe_pkg::scan_state_t st_next,
  output rbbe_pkg::emit_t       res
);
  import rbbe_pkg::*;

  typedef struct packed {
    logic [1:0] n;
    logic [7:0] c0;
    logic [7:0] c1;
    mode_t      mode;
    logic       skip;
  } rule_t;

  // Ordinary rules for a byte inside a bracket expression
  function automatic rule_t bracket_rule(logic [7:0] c, logic first, logic last);
    rule_t r;
    r.n    = 2'd1;
    r.c0   = c;
    r.c1   = c;
    r.mode = MODE_IN;
    r.skip = 1'b0;
    if (c == CH_RBR && !first) begin
      r.mode = MODE_OUT;
    end else if (c == CH_LBR) begin
      if (!last) begin
        r.n    = 2'd0;
        r.mode = MODE_PEND_OPEN;
      end
    end else if (c == CH_BSL) begin
      r.n    = 2'd2;
      r.skip = 1'b1;
    end
    return r;
  endfunction

  // A byte inside a class with no delimiter held
  function automatic rule_t class_rule(logic [7:0] c, logic last, logic [7:0] delim);
    rule_t r;
    r.n    = 2'd1;
    r.c0   = c;
    r.c1   = c;
    r.mode = MODE_CLASS;
    r.skip = 1'b0;
    if (last) begin
      if (c == CH_BSL) r.n = 2'd2;
    end else if (c == delim) begin
      r.n    = 2'd0;
      r.mode = MODE_PEND_DELIM;
    end
    return r;
  endfunction

  logic       swallow;
  logic       pre_en;
  logic [7:0] pre_char;
  logic [7:0] delim_next;
  rule_t      body;

  always_comb begin
    swallow    = st.skip && (in_char == CH_BSL);
    pre_en     = 1'b0;
    pre_char   = in_char;
    delim_next = st.delim;
    body.n     = 2'd0;
    body.c0    = in_char;
    body.c1    = in_char;
    body.mode  = st.mode;
    body.skip  = 1'b0;

    if (!swallow) begin
      unique case (st.mode)
        MODE_OPEN: begin
          if (in_char == CH_CARET) begin
            body.n    = 2'd1;
            body.mode = MODE_FIRST;
          end else begin
            body = bracket_rule(in_char, 1'b1, in_last);
          end
        end
        MODE_FIRST: body = bracket_rule(in_char, 1'b1, in_last);
        MODE_IN:    body = bracket_rule(in_char, 1'b0, in_last);
        MODE_PEND_OPEN: begin
          pre_en   = 1'b1;
          pre_char = CH_LBR;
          if (in_char == CH_COLON || in_char == CH_DOT || in_char == CH_EQ) begin
            body.n     = 2'd1;
            body.mode  = MODE_CLASS;
            delim_next = in_char;
          end else begin
            body = bracket_rule(in_char, 1'b0, in_last);
          end
        end
        MODE_CLASS: body = class_rule(in_char, in_last, st.delim);
        MODE_PEND_DELIM: begin
          pre_en   = 1'b1;
          pre_char = st.delim;
          if (in_char == CH_RBR) begin
            body.n    = 2'd1;
            body.mode = MODE_IN;
          end else begin
            body = class_rule(in_char, in_last, st.delim);
          end
        end
        default: begin
          body.n    = 2'd1;
          body.mode = (in_char == CH_LBR) ? MODE_OPEN : MODE_OUT;
        end
      endcase
    end

    // End of string puts everything back to reset
    if (in_last) begin
      st_next.mode  = MODE_OUT;
      st_next.delim = 8'd0;
      st_next.skip  = 1'b0;
    end else begin
      st_next.mode  = body.mode;
      st_next.delim = delim_next;
      st_next.skip  = body.skip;
    end

    res.n = 2'({1'b0, pre_en} + body.n);
    if (pre_en) begin
      res.chars[0] = pre_char;
      res.chars[1] = body.c0;
      res.chars[2] = body.c1;
    end else begin
      res.chars[0] = body.c0;
      res.chars[1] = body.c1;
      res.chars[2] = body.c1;
    end
  end

endmodule

`default_nettype wire

### hdl/regex_bracket_backslash_escaper_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming escaper for regular-expression strings: bytes come in on the
// s_axis side with tlast on the final byte, and go out on m_axis with a
// lone backslash inside bracket expressions doubled, an already doubled
// pair kept, and [:x:], [.x.], [=x=] classes passed untouched. Each input
// item yields zero to three output items; when the final byte yields no
// byte, one marker item (tuser 0, tdata 0, tlast 1) closes the string.
// Timing: the result of an item is computed in the accept cycle and held
// in a three-entry result register that drains one item per cycle while
// m_axis_tready is high, and the next item is taken in the cycle the last
// byte of the previous one leaves. Items that give one byte flow at one
// per cycle while the output is ready; throughput is set by the drain of
// the result register. An item that gives no byte, unless final, leaves it empty.
module regex_bracket_backslash_escaper_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tuser,   // [0] out_has_char
  output logic       m_axis_tlast    // out_last
);
  import rbbe_pkg::*;

  scan_state_t             st;
  scan_state_t             st_next;
  emit_t                   res;
  logic [MAX_OUT-1:0][7:0] res_chars;
  logic [1:0]              res_cnt;
  logic [1:0]              res_idx;
  logic                    res_marker;
  logic                    res_last;
  logic                    in_acc;
  logic                    out_acc;
  logic                    on_final;

  rbbe_step u_step (
    .st      (st),
    .in_char (s_axis_tdata),
    .in_last (s_axis_tlast),
    .st_next (st_next),
    .res     (res)
  );

  // Handshake: take a new item once the buffer empties this cycle
  assign on_final      = (res_idx == res_cnt - 2'd1);
  assign m_axis_tvalid = (res_cnt != 2'd0);
  assign s_axis_tready = (res_cnt == 2'd0) || (m_axis_tready && on_final);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  assign m_axis_tdata  = res_marker ? 8'd0 : res_chars[res_idx];
  assign m_axis_tuser  = !res_marker;
  assign m_axis_tlast  = res_last && on_final;

  // Scan state and result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode    <= MODE_OUT;
      st.delim   <= 8'd0;
      st.skip    <= 1'b0;
      res_cnt    <= 2'd0;
      res_idx    <= 2'd0;
      res_marker <= 1'b0;
      res_last   <= 1'b0;
    end else if (in_acc) begin
      st        <= st_next;
      res_idx   <= 2'd0;
      res_chars <= res.chars;
      res_last  <= s_axis_tlast;
      if (res.n != 2'd0) begin
        res_cnt    <= res.n;
        res_marker <= 1'b0;
      end else if (s_axis_tlast) begin
        res_cnt    <= 2'd1;
        res_marker <= 1'b1;
      end else begin
        res_cnt    <= 2'd0;
        res_marker <= 1'b0;
      end
    end else if (out_acc) begin
      if (on_final) begin
        res_cnt <= 2'd0;
        res_idx <= 2'd0;
      end else begin
        res_idx <= res_idx + 2'd1;
      end
    end
  end

  // The end marker only ever closes a string
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
    else $error("marker item without tlast");

  // Read pointer stays inside the filled part of the buffer
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (res_cnt != 2'd0) |-> (res_idx < res_cnt))
    else $error("result index past fill count");

  // The final byte of a string returns the scanner to its reset state
  a_end_reset: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_axis_tlast) |=> (st.mode == MODE_OUT && !st.skip && st.delim == 8'd0))
    else $error("scanner state not cleared at end of string");

  // A string-ending item always leaves at least one result behind
  a_end_output: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_axis_tlast) |=> (m_axis_tvalid && res_last))
    else $error("no closing result after final byte");

endmodule

`default_nettype wire
